// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/lrm_pkg.sv -----
// Types and constants of the load-reserved monitor.
package lrm_pkg;

	localparam int KIND_W = 2;
	localparam int HART_W = 3;
	localparam int ADDR_W = 64;
	localparam int LEN_W  = 4;
	localparam int END_W  = ADDR_W + 1;

	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [HART_W-1:0] hart_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [END_W-1:0]  end_t;

	// Access kinds.
	localparam kind_t KIND_LR = 2'd0;
	localparam kind_t KIND_SC = 2'd1;
	localparam kind_t KIND_ST = 2'd2;

	// One access held in the input stage, with its 65-bit range end.
	typedef struct packed {
		kind_t kind;
		hart_t hart;
		addr_t address;
		end_t  range_end;
	} acc_t;

	// Outcome of one access.
	typedef struct packed {
		logic sc_ok;
		logic cleared;
	} res_t;

endpackage

// ----- hw/rtl/lrm_req_if.sv -----
// Request channel of the load-reserved monitor.
interface lrm_req_if;
	import lrm_pkg::*;

	logic  valid;
	logic  ready;
	kind_t kind;
	hart_t hart;
	addr_t address;
	len_t  length;

	modport source (output valid, kind, hart, address, length, input ready);
	modport sink (input valid, kind, hart, address, length, output ready);
endinterface

// ----- hw/rtl/lrm_rsp_if.sv -----
// Response channel of the load-reserved monitor.
interface lrm_rsp_if;
	logic valid;
	logic ready;
	logic sc_succeeded;
	logic others_cleared;

	modport source (output valid, sc_succeeded, others_cleared, input ready);
	modport sink (input valid, sc_succeeded, others_cleared, output ready);
endinterface

// ----- hw/rtl/lrm_in_stage.sv -----
// Input register: clamps the length and forms the 65-bit range end.
module lrm_in_stage #(
	parameter int MAX_LEN = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	lrm_req_if.sink        req,
	input  logic           adv,
	output logic           valid_s1,
	output lrm_pkg::acc_t  acc_s1
);
	import lrm_pkg::*;

	len_t len_c;
	acc_t acc_d;
	logic take;

	// Clamp an oversized length and extend the end by one carry bit.
	always_comb begin
		len_c = ({1'b0, req.length} > (LEN_W+1)'(MAX_LEN)) ? LEN_W'(MAX_LEN) : req.length;
		acc_d.kind      = req.kind;
		acc_d.hart      = req.hart;
		acc_d.address   = req.address;
		acc_d.range_end = {1'b0, req.address} + END_W'(len_c);
	end

	// The stage takes a new beat when it is empty or moving on.
	assign req.ready = !valid_s1 || adv;
	assign take      = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			acc_s1 <= acc_d;
		end
	end
endmodule

// ----- hw/rtl/lrm_resv_table.sv -----
// Per-hart reservation table with its own range comparators for each entry.
module lrm_resv_table #(
	parameter int NUM_HARTS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lrm_pkg::acc_t        acc_s1,
	input  logic                 adv,
	output lrm_pkg::res_t        res,
	output logic [NUM_HARTS-1:0] resv_valid
);
	import lrm_pkg::*;

	logic [NUM_HARTS-1:0] valid_q;
	addr_t                base_q [NUM_HARTS];
	end_t                 end_q  [NUM_HARTS];

	logic [NUM_HARTS-1:0] own;
	logic [NUM_HARTS-1:0] fits;
	logic [NUM_HARTS-1:0] ovl;
	logic                 is_lr;
	logic                 is_sc;
	logic                 clear_en;

	assign is_lr = (acc_s1.kind == KIND_LR);
	assign is_sc = (acc_s1.kind == KIND_SC);

	// Compare the access against every entry in parallel.
	always_comb begin
		for (int i = 0; i < NUM_HARTS; i++) begin
			own[i]  = (32'(acc_s1.hart) == 32'(i));
			fits[i] = (acc_s1.address >= base_q[i]) && (acc_s1.range_end <= end_q[i]);
			ovl[i]  = valid_q[i] && !own[i]
				&& ({1'b0, acc_s1.address} < end_q[i])
				&& (acc_s1.range_end > {1'b0, base_q[i]});
		end
	end

	// A passing store-conditional then acts as a plain store.
	always_comb begin
		res.sc_ok   = is_sc && |(own & valid_q & fits);
		clear_en    = (acc_s1.kind == KIND_ST) || res.sc_ok;
		res.cleared = clear_en && |ovl;
	end

	// Valid bits: set by load-reserved, dropped by own SC or by another hart's overlapping store or passing SC.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (adv) begin
			for (int i = 0; i < NUM_HARTS; i++) begin
				if (is_lr && own[i]) begin
					valid_q[i] <= 1'b1;
				end else if ((is_sc && own[i]) || (clear_en && ovl[i])) begin
					valid_q[i] <= 1'b0;
				end
			end
		end
	end

	// Range of each reservation, written by load-reserved.
	always_ff @(posedge clk) begin
		if (adv && is_lr) begin
			for (int i = 0; i < NUM_HARTS; i++) begin
				if (own[i]) begin
					base_q[i] <= acc_s1.address;
					end_q[i]  <= acc_s1.range_end;
				end
			end
		end
	end

	assign resv_valid = valid_q;
endmodule

// ----- hw/rtl/lrm_out_stage.sv -----
// Result register that holds a beat until the response side takes it.
module lrm_out_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  lrm_pkg::res_t  res,
	output logic           can_take,
	lrm_rsp_if.source      rsp
);
	import lrm_pkg::*;

	res_t res_q;
	logic valid_q;

	assign can_take = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign rsp.valid          = valid_q;
	assign rsp.sc_succeeded   = res_q.sc_ok;
	assign rsp.others_cleared = res_q.cleared;
endmodule

// ----- hw/rtl/load_reserved_monitor_top.sv -----
// An accepted beat enters the input register; its result then moves to the result register.
// Throughput: one access per cycle while the response side takes results; each entry
// of the reservation table has its own comparators, all harts checked in parallel in one pass.
// Reset clears every reservation and both pipeline valid flags; the reservation
// ranges themselves are not reset and are only read while their entry is valid.
module load_reserved_monitor_top #(
	parameter int NUM_HARTS = 8,
	parameter int MAX_LEN   = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	lrm_req_if.sink   req,
	lrm_rsp_if.source rsp
);
	import lrm_pkg::*;
`include "assert_macros.svh"

	logic                 valid_s1;
	acc_t                 acc_s1;
	res_t                 res;
	logic                 can_take;
	logic                 adv;
	logic [NUM_HARTS-1:0] resv_valid;

	// The input stage moves on when the result register can take its beat.
	assign adv = valid_s1 && can_take;

	lrm_in_stage #(
		.MAX_LEN(MAX_LEN)
	) u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.adv     (adv),
		.valid_s1(valid_s1),
		.acc_s1  (acc_s1)
	);

	lrm_resv_table #(
		.NUM_HARTS(NUM_HARTS)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc_s1    (acc_s1),
		.adv       (adv),
		.res       (res),
		.resv_valid(resv_valid)
	);

	lrm_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.res     (res),
		.can_take(can_take),
		.rsp     (rsp)
	);

	// An empty result register never stalls the request side.
	`ASSERT_RST(a_ready_when_empty, clk, arst_n, !rsp.valid |-> req.ready, "request stalled with empty output")
	// Only a store-conditional can report success.
	`ASSERT_RST(a_sc_kind, clk, arst_n, (adv && res.sc_ok) |-> (acc_s1.kind == KIND_SC), "sc success on wrong kind")
	// Clearing other harts removes at least one reservation.
	`ASSERT_RST(a_clear_drops, clk, arst_n, (adv && res.cleared) |=> ($countones(resv_valid) < $past($countones(resv_valid))), "clear reported but no reservation dropped")
	// No reservation is held once a clock edge has seen reset.
	`ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> (resv_valid == '0), "reservation held during reset")
endmodule

// ----- bench/reservation_checker.sv -----
// Reservation checker: predicts each access outcome of the monitor and compares the result beats.
module reservation_checker #(
	parameter int NUM_HARTS = 8,
	parameter int MAX_LEN   = 8
) (
	input  logic clk,
	input  logic arst_n,
	lrm_req_if   req,
	lrm_rsp_if   rsp,
	output int   mismatches,
	output int   pending,
	output int   sc_passes,
	output int   clear_events
);
	timeunit 1ns;
	timeprecision 1ps;

	import lrm_pkg::*;

	// Predicted reservation table, one entry per hart.
	logic  held[NUM_HARTS];
	addr_t held_base[NUM_HARTS];
	len_t  held_size[NUM_HARTS];

	// Predicted outcomes of accepted accesses, oldest first.
	res_t outcome_q[$];

	// Drop every reservation of another hart that overlaps [a, a_end).
	function automatic logic drop_overlaps(int self, addr_t a, end_t a_end);
		logic any;
		end_t b_end;
		any = 1'b0;
		for (int i = 0; i < NUM_HARTS; i++) begin
			if (i != self && held[i]) begin
				b_end = {1'b0, held_base[i]} + end_t'(held_size[i]);
				if ({1'b0, a} < b_end && a_end > {1'b0, held_base[i]}) begin
					held[i] = 1'b0;
					any = 1'b1;
				end
			end
		end
		return any;
	endfunction

	// Apply one access to the predicted table and return its outcome.
	function automatic res_t predict_access(kind_t k, hart_t h, addr_t a, len_t l);
		len_t n;
		end_t a_end;
		end_t b_end;
		res_t r;
		int   slot;
		slot = int'(h);
		n = (int'(l) > MAX_LEN) ? len_t'(MAX_LEN) : l;
		a_end = {1'b0, a} + end_t'(n);
		r = '0;
		case (k)
			KIND_LR: begin
				if (slot < NUM_HARTS) begin
					held[slot] = 1'b1;
					held_base[slot] = a;
					held_size[slot] = n;
				end
			end
			KIND_SC: begin
				// The reservation goes away whether or not the store lands.
				if (slot < NUM_HARTS && held[slot]) begin
					b_end = {1'b0, held_base[slot]} + end_t'(held_size[slot]);
					held[slot] = 1'b0;
					if (a >= held_base[slot] && a_end <= b_end) begin
						r.sc_ok = 1'b1;
						r.cleared = drop_overlaps(slot, a, a_end);
					end
				end
			end
			KIND_ST: begin
				r.cleared = drop_overlaps(slot, a, a_end);
			end
			default: ;
		endcase
		return r;
	endfunction

	// Predict on each request beat, then compare each result beat with the oldest outcome.
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		int   bad;
		if (!arst_n) begin
			for (int i = 0; i < NUM_HARTS; i++)
				held[i] = 1'b0;
			outcome_q.delete();
			pending <= 0;
		end else begin
			bad = 0;
			if (req.valid && req.ready)
				outcome_q = {outcome_q,
					predict_access(req.kind, req.hart, req.address, req.length)};
			if (rsp.valid && rsp.ready) begin
				got = {rsp.sc_succeeded, rsp.others_cleared};
				if (outcome_q.size() == 0) begin
					$error("result beat arrived with no access outstanding");
					bad++;
				end else begin
					want = outcome_q.pop_front();
					if (got.sc_ok !== want.sc_ok) begin
						$error("sc_succeeded: expected %0b, actual %0b", want.sc_ok, got.sc_ok);
						bad++;
					end
					if (got.cleared !== want.cleared) begin
						$error("others_cleared: expected %0b, actual %0b",
							want.cleared, got.cleared);
						bad++;
					end
					sc_passes <= sc_passes + int'(want.sc_ok);
					clear_events <= clear_events + int'(want.cleared);
				end
			end
			mismatches <= mismatches + bad;
			pending <= outcome_q.size();
		end
	end

endmodule

// ----- bench/tb_top.sv -----
// Top of the load-reserved monitor testbench: clock, reset, access stimulus and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lrm_pkg::*;

	localparam int NUM_HARTS   = 8;
	localparam int MAX_LEN     = 8;
	localparam int ITEM_TARGET = 1000;
	localparam int IDLE_LIMIT  = 2000;

	logic clk;
	logic arst_n;

	lrm_req_if req_bus();
	lrm_rsp_if rsp_bus();

	int mismatches;
	int pending;
	int sc_passes;
	int clear_events;
	int kind_count[4];
	int items_sent;
	int idle_cycles;
	bit quiet;

	load_reserved_monitor_top #(
		.NUM_HARTS(NUM_HARTS),
		.MAX_LEN(MAX_LEN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus)
	);

	reservation_checker #(
		.NUM_HARTS(NUM_HARTS),
		.MAX_LEN(MAX_LEN)
	) resv_chk (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus),
		.mismatches(mismatches),
		.pending(pending),
		.sc_passes(sc_passes),
		.clear_events(clear_events)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Idle length for either side: mostly none, sometimes a few cycles, rarely a long stretch.
	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Addresses cluster in a few windows so that ranges collide often.
	function automatic addr_t pick_addr();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 64'h1000 + addr_t'($urandom_range(0, 47));
		else if (r < 60)
			return 64'hFFFF_FFFF_FFFF_FFE0 + addr_t'($urandom_range(0, 31));
		else if (r < 70)
			return addr_t'($urandom_range(0, 31));
		return {$urandom, $urandom};
	endfunction

	// Drive one request beat; entered and left at a falling edge.
	task automatic send_access(input kind_t k, input hart_t h, input addr_t a, input len_t l);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.kind <= k;
		req_bus.hart <= h;
		req_bus.address <= a;
		req_bus.length <= l;
		do
			@(posedge clk);
		while (req_bus.ready !== 1'b1);
		kind_count[k]++;
		if (k != 2'd3)
			items_sent++;
		@(negedge clk);
	endtask

	// Hand-picked corner cases of the reservation rules.
	task automatic run_directed();
		// Store-conditional with no reservation held.
		send_access(KIND_SC, 3'd0, 64'h100, 4'd8);
		// Adjacent store does not touch the reservation; one byte lower does.
		send_access(KIND_LR, 3'd0, 64'h100, 4'd8);
		send_access(KIND_ST, 3'd1, 64'h108, 4'd1);
		send_access(KIND_ST, 3'd1, 64'h107, 4'd1);
		// Exact match passes; a second one finds nothing.
		send_access(KIND_LR, 3'd0, 64'h100, 4'd8);
		send_access(KIND_SC, 3'd0, 64'h100, 4'd8);
		send_access(KIND_SC, 3'd0, 64'h100, 4'd8);
		// A passing store-conditional clears an overlapping reservation of another hart.
		send_access(KIND_LR, 3'd1, 64'h200, 4'd4);
		send_access(KIND_LR, 3'd2, 64'h202, 4'd2);
		send_access(KIND_SC, 3'd1, 64'h200, 4'd4);
		send_access(KIND_SC, 3'd2, 64'h202, 4'd2);
		// Ranges that end past the top of the address space.
		send_access(KIND_LR, 3'd3, 64'hFFFF_FFFF_FFFF_FFF8, 4'd8);
		send_access(KIND_SC, 3'd3, 64'hFFFF_FFFF_FFFF_FFFC, 4'd4);
		send_access(KIND_LR, 3'd3, 64'hFFFF_FFFF_FFFF_FFF8, 4'd8);
		send_access(KIND_ST, 3'd4, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
		// Zero-length stores and store-conditionals.
		send_access(KIND_LR, 3'd5, 64'h300, 4'd4);
		send_access(KIND_ST, 3'd6, 64'h300, 4'd0);
		send_access(KIND_ST, 3'd6, 64'h302, 4'd0);
		send_access(KIND_LR, 3'd5, 64'h300, 4'd4);
		send_access(KIND_SC, 3'd5, 64'h304, 4'd0);
		// Oversized length is clamped to the maximum.
		send_access(KIND_LR, 3'd7, 64'h400, 4'd15);
		send_access(KIND_SC, 3'd7, 64'h407, 4'd1);
		// The unused kind leaves the table alone; a store by the owner never clears itself.
		send_access(KIND_LR, 3'd7, 64'h0, 4'd1);
		send_access(kind_t'(2'd3), 3'd0, 64'h0, 4'd8);
		send_access(KIND_ST, 3'd7, 64'h0, 4'd1);
		send_access(KIND_SC, 3'd7, 64'h0, 4'd1);
	endtask

	// One reservation, some traffic from other harts near it, then the owner's store-conditional.
	task automatic run_reservation_sequence();
		hart_t h;
		hart_t o;
		addr_t a;
		addr_t near_a;
		int    l;
		int    off;
		int    l2;
		h = hart_t'($urandom_range(0, NUM_HARTS - 1));
		a = pick_addr();
		l = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(1, 8);
		send_access(KIND_LR, h, a, len_t'(l));
		repeat ($urandom_range(0, 3)) begin
			o = hart_t'($urandom_range(0, NUM_HARTS - 1));
			near_a = a + addr_t'($urandom_range(0, 24)) - addr_t'(8);
			case ($urandom_range(0, 3))
				0: send_access(KIND_LR, o, near_a, len_t'($urandom_range(0, 15)));
				1: send_access(KIND_ST, o, near_a, len_t'($urandom_range(0, 15)));
				2: send_access(KIND_ST, o, pick_addr(), len_t'($urandom_range(0, 15)));
				default: send_access(KIND_SC, o, near_a, len_t'($urandom_range(0, 8)));
			endcase
		end
		if (l > MAX_LEN)
			l = MAX_LEN;
		off = $urandom_range(0, l);
		l2 = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, l - off);
		if ($urandom_range(0, 9) == 0)
			send_access(KIND_SC, h, a - addr_t'(1), len_t'(l2));
		else
			send_access(KIND_SC, h, a + addr_t'(off), len_t'(l2));
	endtask

	// Result side back-pressure.
	initial begin
		int stall;
		stall = 0;
		rsp_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall == 0)
				stall = pick_gap();
			if (stall > 0) begin
				rsp_bus.ready <= 1'b0;
				stall--;
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no beat on either channel.
	always @(posedge clk) begin
		if (!arst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: no beat for %0d cycles, %0d results outstanding.",
					IDLE_LIMIT, pending);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Main stimulus and verdict.
	initial begin
		req_bus.valid = 1'b0;
		req_bus.kind = KIND_LR;
		req_bus.hart = '0;
		req_bus.address = '0;
		req_bus.length = '0;
		arst_n = 1'b0;
		quiet = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		while (items_sent < ITEM_TARGET) begin
			// Now and then switch between idling and back-to-back stretches.
			if ($urandom_range(0, 19) == 0)
				quiet = ~quiet;
			if ($urandom_range(0, 9) < 7)
				run_reservation_sequence();
			else
				send_access(kind_t'($urandom_range(0, 3)), hart_t'($urandom_range(0, 7)),
					pick_addr(), len_t'($urandom_range(0, 15)));
		end
		req_bus.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		$display("Sent %0d accesses: %0d load-reserved, %0d store-conditional, %0d stores, %0d unused.",
			kind_count[0] + kind_count[1] + kind_count[2] + kind_count[3],
			kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
		$display("%0d store-conditionals passed; %0d accesses removed another hart's reservation.",
			sc_passes, clear_events);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/lrm_pkg.sv
hw/rtl/lrm_req_if.sv
hw/rtl/lrm_rsp_if.sv
hw/rtl/lrm_in_stage.sv
hw/rtl/lrm_resv_table.sv
hw/rtl/lrm_out_stage.sv
hw/rtl/load_reserved_monitor_top.sv
bench/reservation_checker.sv
bench/tb_top.sv
